// ----- hw/rtl/mm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mm_pkg;

    localparam int MAX_DIM_DEF = 8;
    localparam int DIM_W       = 4;
    localparam int POS_W       = 3;
    localparam int ELEM_W      = 32;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B_ROWS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 2'd3;

    typedef struct packed {
        logic                     select_b;
        logic [POS_W-1:0]         row_index;
        logic [POS_W-1:0]         col_index;
        logic signed [ELEM_W-1:0] element;
        logic                     go;
    } mm_in_t;

    typedef struct packed {
        logic [POS_W-1:0]         out_row;
        logic [POS_W-1:0]         out_col;
        logic signed [ELEM_W-1:0] product;
        logic                     saturated;
        logic                     misaligned;
        logic                     last;
    } mm_out_t;

    // one store read issued by the sequencer, tagged for the accumulator
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mm_issue_t;

endpackage

`default_nettype wire

// ----- hw/rtl/matrix_multiply.sv -----
`timescale 1ns / 1ps
`default_nettype none

// General matrix multiply C = A x B on signed Q16.16 elements held in two
// on-chip stores. Each input transaction writes one element of A or B and is
// taken while idle; a transaction with go set also starts the product run,
// and no further input is taken until the last result has been handed to the
// output register. Each product element is computed by a single
// multiply-accumulate unit reading one A and one B entry per cycle. Each result
// takes a start step, which waits for the output register to be free, then
// a_cols store reads, then the read, multiply and accumulate stages drain. Results
// leave in row-major order with last set on the final one; if a_cols differs
// from b_rows a single result with misaligned set is returned instead.
// Dimension registers of 0 act as 1 and values above MAX_DIM act as MAX_DIM.
// Loads whose row or column is not below MAX_DIM store nothing.

module matrix_multiply
    import mm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire mm_in_t               s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output mm_out_t                   m_data,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_wdata
);

    localparam int IW = $clog2(MAX_DIM);
    localparam int AW = 2 * IW;
    localparam logic [DIM_W-1:0] MAX_D = DIM_W'(MAX_DIM);

    logic [DIM_W-1:0] a_rows_reg, a_cols_reg, b_rows_reg, b_cols_reg;
    logic [DIM_W-1:0] dim_wdata;

    logic                     s_accept;
    logic                     idx_ok;
    logic                     ctrl_idle;
    logic                     out_free;
    logic                     mac_done;
    logic                     err_load;
    mm_issue_t                issue;
    logic [AW-1:0]            rd_addr_a, rd_addr_b;
    logic signed [ELEM_W-1:0] rd_data_a, rd_data_b;
    logic signed [ELEM_W-1:0] mac_product;
    logic                     mac_sat;
    logic [IW-1:0]            row_idx, col_idx;
    logic                     elem_last;

    logic    m_valid_reg;
    mm_out_t m_data_reg;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        if (v == '0) begin
            return DIM_W'(1);
        end else if (v > MAX_D) begin
            return MAX_D;
        end else begin
            return v;
        end
    endfunction

    assign dim_wdata = clamp_dim(cfg_wdata);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_rows_reg <= DIM_W'(1);
            a_cols_reg <= DIM_W'(1);
            b_rows_reg <= DIM_W'(1);
            b_cols_reg <= DIM_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_A_ROWS: a_rows_reg <= dim_wdata;
                REG_A_COLS: a_cols_reg <= dim_wdata;
                REG_B_ROWS: b_rows_reg <= dim_wdata;
                REG_B_COLS: b_cols_reg <= dim_wdata;
                default:    a_rows_reg <= a_rows_reg;
            endcase
        end
    end

    assign s_ready  = ctrl_idle;
    assign s_accept = s_valid && s_ready;
    assign idx_ok   = ({1'b0, s_data.row_index} < MAX_D) &&
                      ({1'b0, s_data.col_index} < MAX_D);
    assign out_free = !m_valid_reg || m_ready;

    mm_store #(
        .MAX_DIM (MAX_DIM)
    ) u_store (
        .aclk      (aclk),
        .wr_en     (s_accept && idx_ok),
        .wr_sel_b  (s_data.select_b),
        .wr_addr   ({s_data.row_index[IW-1:0], s_data.col_index[IW-1:0]}),
        .wr_data   (s_data.element),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    mm_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .go_accept (s_accept && s_data.go),
        .m_dim     (a_rows_reg),
        .n_dim     (a_cols_reg),
        .l_dim     (b_rows_reg),
        .p_dim     (b_cols_reg),
        .out_free  (out_free),
        .mac_done  (mac_done),
        .idle      (ctrl_idle),
        .issue     (issue),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .err_load  (err_load),
        .row_idx   (row_idx),
        .col_idx   (col_idx),
        .elem_last (elem_last)
    );

    mm_mac #(
        .MAX_DIM (MAX_DIM)
    ) u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .issue     (issue),
        .a_data    (rd_data_a),
        .b_data    (rd_data_b),
        .done      (mac_done),
        .product   (mac_product),
        .saturated (mac_sat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (mac_done || err_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mac_done) begin
            m_data_reg.out_row    <= {{(POS_W-IW){1'b0}}, row_idx};
            m_data_reg.out_col    <= {{(POS_W-IW){1'b0}}, col_idx};
            m_data_reg.product    <= mac_product;
            m_data_reg.saturated  <= mac_sat;
            m_data_reg.misaligned <= 1'b0;
            m_data_reg.last       <= elem_last;
        end else if (err_load) begin
            m_data_reg.out_row    <= '0;
            m_data_reg.out_col    <= '0;
            m_data_reg.product    <= '0;
            m_data_reg.saturated  <= 1'b0;
            m_data_reg.misaligned <= 1'b1;
            m_data_reg.last       <= 1'b1;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a finished element must never find the output slot still occupied
    a_done_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_done |-> out_free)
        else $error("result arrived while output register busy");

    a_done_err_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mac_done && err_load))
        else $error("product and shape error loaded together");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (mac_done || err_load) |=> m_valid)
        else $error("loaded result not presented");

    a_busy_no_input: assert property (@(posedge aclk) disable iff (!aresetn)
        issue.valid |-> !s_ready)
        else $error("input taken while store reads are running");

endmodule

`default_nettype wire

// ----- hw/rtl/mm_store.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mm_store
    import mm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             wr_en,
    input  wire logic                             wr_sel_b,
    input  wire logic [2*$clog2(MAX_DIM)-1:0]     wr_addr,
    input  wire logic [ELEM_W-1:0]                wr_data,
    input  wire logic [2*$clog2(MAX_DIM)-1:0]     rd_addr_a,
    input  wire logic [2*$clog2(MAX_DIM)-1:0]     rd_addr_b,
    output logic signed [ELEM_W-1:0]              rd_data_a,
    output logic signed [ELEM_W-1:0]              rd_data_b
);

    localparam int IW    = $clog2(MAX_DIM);
    localparam int AW    = 2 * IW;
    localparam int DEPTH = 1 << AW;

    logic [ELEM_W-1:0] mem_a [DEPTH];
    logic [ELEM_W-1:0] mem_b [DEPTH];
    logic [ELEM_W-1:0] rd_a_reg;
    logic [ELEM_W-1:0] rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en && !wr_sel_b) begin
            mem_a[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem_a[rd_addr_a];
    end

    always_ff @(posedge aclk) begin
        if (wr_en && wr_sel_b) begin
            mem_b[wr_addr] <= wr_data;
        end
        rd_b_reg <= mem_b[rd_addr_b];
    end

    assign rd_data_a = $signed(rd_a_reg);
    assign rd_data_b = $signed(rd_b_reg);

endmodule

`default_nettype wire

// ----- hw/rtl/mm_mac.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mm_mac
    import mm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire mm_issue_t                issue,
    input  wire logic signed [ELEM_W-1:0] a_data,
    input  wire logic signed [ELEM_W-1:0] b_data,
    output logic                          done,
    output logic signed [ELEM_W-1:0]      product,
    output logic                          saturated
);

    localparam int PROD_W = 2 * ELEM_W;
    localparam int ACC_W  = PROD_W + $clog2(MAX_DIM);
    localparam int SH_W   = ACC_W - 16;

    mm_issue_t                  tag0_reg;
    mm_issue_t                  tag1_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;
    logic                       done_reg;
    logic signed [SH_W-1:0]     shifted;
    logic [SH_W-32:0]           top_bits;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag0_reg <= '0;
            tag1_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            tag0_reg <= issue;
            tag1_reg <= tag0_reg;
            done_reg <= tag1_reg.valid && tag1_reg.last;
        end
    end

    // read data lines up with tag0, product with tag1
    always_ff @(posedge aclk) begin
        prod_reg <= a_data * b_data;
        if (tag1_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

    always_comb begin
        if (tag1_reg.first) begin
            acc_next = ACC_W'(prod_reg);
        end else begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    // floor shift, then clip when the bits above the result are not all sign
    assign shifted  = SH_W'(acc_reg >>> 16);
    assign top_bits = shifted[SH_W-1:31];

    always_comb begin
        if ((&top_bits) || !(|top_bits)) begin
            product   = shifted[ELEM_W-1:0];
            saturated = 1'b0;
        end else if (shifted[SH_W-1]) begin
            product   = 32'sh8000_0000;
            saturated = 1'b1;
        end else begin
            product   = 32'sh7FFF_FFFF;
            saturated = 1'b1;
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/mm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mm_ctrl
    import mm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          go_accept,
    input  wire logic [DIM_W-1:0]              m_dim,
    input  wire logic [DIM_W-1:0]              n_dim,
    input  wire logic [DIM_W-1:0]              l_dim,
    input  wire logic [DIM_W-1:0]              p_dim,
    input  wire logic                          out_free,
    input  wire logic                          mac_done,
    output logic                               idle,
    output mm_issue_t                          issue,
    output logic [2*$clog2(MAX_DIM)-1:0]       rd_addr_a,
    output logic [2*$clog2(MAX_DIM)-1:0]       rd_addr_b,
    output logic                               err_load,
    output logic [$clog2(MAX_DIM)-1:0]         row_idx,
    output logic [$clog2(MAX_DIM)-1:0]         col_idx,
    output logic                               elem_last
);

    localparam int IW = $clog2(MAX_DIM);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_ISSUE = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] j_reg, j_next;
    logic [IW-1:0] k_reg, k_next;
    logic          k_last, i_last, j_last;

    assign k_last = ({{(DIM_W-IW){1'b0}}, k_reg} == n_dim - DIM_W'(1));
    assign i_last = ({{(DIM_W-IW){1'b0}}, i_reg} == m_dim - DIM_W'(1));
    assign j_last = ({{(DIM_W-IW){1'b0}}, j_reg} == p_dim - DIM_W'(1));

    always_comb begin
        state_next  = state_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        issue       = '0;
        err_load    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (go_accept) begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                // one element in flight at a time, so the output slot is ours
                if (out_free) begin
                    if (n_dim != l_dim) begin
                        err_load   = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        k_next     = '0;
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE: begin
                issue.valid = 1'b1;
                issue.first = (k_reg == '0);
                issue.last  = k_last;
                if (k_last) begin
                    state_next = ST_DRAIN;
                end else begin
                    k_next = k_reg + IW'(1);
                end
            end
            ST_DRAIN: begin
                if (mac_done) begin
                    if (i_last && j_last) begin
                        state_next = ST_IDLE;
                    end else if (j_last) begin
                        j_next     = '0;
                        i_next     = i_reg + IW'(1);
                        state_next = ST_START;
                    end else begin
                        j_next     = j_reg + IW'(1);
                        state_next = ST_START;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    assign idle      = (state_reg == ST_IDLE);
    assign rd_addr_a = {i_reg, k_reg};
    assign rd_addr_b = {k_reg, j_reg};
    assign row_idx   = i_reg;
    assign col_idx   = j_reg;
    assign elem_last = i_last && j_last;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import mm_pkg::*;

    localparam int QUIET_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 24;
    localparam int ITEM_TARGET   = 220;
    localparam int MAX_SHOWN     = 10;

    localparam logic [CFG_IDX_W-1:0] REG_ORDER [4] = '{REG_A_ROWS, REG_A_COLS,
                                                       REG_B_ROWS, REG_B_COLS};

    class mm_scoreboard;
        logic signed [ELEM_W-1:0] a_mem [MAX_DIM_DEF*MAX_DIM_DEF];
        logic signed [ELEM_W-1:0] b_mem [MAX_DIM_DEF*MAX_DIM_DEF];
        logic [DIM_W-1:0]         dims [4];
        mm_out_t                  product_q [$];
        int mismatches;
        int inputs_seen;
        int results_seen;
        int sat_seen;
        int misaligned_seen;

        function new();
            foreach (a_mem[i]) begin
                a_mem[i] = '0;
                b_mem[i] = '0;
            end
            foreach (dims[i]) dims[i] = 4'd1;
            mismatches      = 0;
            inputs_seen     = 0;
            results_seen    = 0;
            sat_seen        = 0;
            misaligned_seen = 0;
        endfunction

        static function int effective_dim(logic [DIM_W-1:0] v);
            if (v == 0) return 1;
            if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
            return int'(v);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
            dims[idx] = val;
        endfunction

        function int pending();
            return product_q.size();
        endfunction

        // store the element, and on go queue the whole product in row-major order, or one misaligned result
        function void note_input(mm_in_t it);
            int m, n, l, p;
            logic signed [63:0] prod;
            logic signed [71:0] acc;
            logic signed [71:0] shifted;
            mm_out_t r;
            inputs_seen++;
            if (it.select_b) b_mem[{it.row_index, it.col_index}] = it.element;
            else a_mem[{it.row_index, it.col_index}] = it.element;
            if (!it.go) return;
            m = effective_dim(dims[REG_A_ROWS]);
            n = effective_dim(dims[REG_A_COLS]);
            l = effective_dim(dims[REG_B_ROWS]);
            p = effective_dim(dims[REG_B_COLS]);
            if (n != l) begin
                r = '0;
                r.misaligned = 1'b1;
                r.last       = 1'b1;
                product_q.push_back(r);
                return;
            end
            for (int i = 0; i < m; i++) begin
                for (int j = 0; j < p; j++) begin
                    acc = '0;
                    for (int k = 0; k < n; k++) begin
                        prod = a_mem[i*MAX_DIM_DEF + k] * b_mem[k*MAX_DIM_DEF + j];
                        acc  = acc + prod;
                    end
                    shifted = acc >>> 16;
                    r = '0;
                    r.out_row = i[POS_W-1:0];
                    r.out_col = j[POS_W-1:0];
                    if (shifted > 72'sd2147483647) begin
                        r.product   = 32'sh7FFFFFFF;
                        r.saturated = 1'b1;
                    end else if (shifted < -72'sd2147483648) begin
                        r.product   = 32'sh80000000;
                        r.saturated = 1'b1;
                    end else begin
                        r.product = shifted[ELEM_W-1:0];
                    end
                    r.last = (i == m - 1) && (j == p - 1);
                    product_q.push_back(r);
                end
            end
        endfunction

        function void check_result(mm_out_t got);
            mm_out_t want;
            results_seen++;
            if (product_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected result: row %0d col %0d product %h sat %b mis %b last %b",
                             got.out_row, got.out_col, got.product, got.saturated,
                             got.misaligned, got.last);
                return;
            end
            want = product_q.pop_front();
            if (want.saturated) sat_seen++;
            if (want.misaligned) misaligned_seen++;
            if (got.out_row !== want.out_row || got.out_col !== want.out_col ||
                got.product !== want.product || got.saturated !== want.saturated ||
                got.misaligned !== want.misaligned || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN) begin
                    $display("mismatch: expected row %0d col %0d product %h sat %b mis %b last %b",
                             want.out_row, want.out_col, want.product, want.saturated,
                             want.misaligned, want.last);
                    $display("          actual   row %0d col %0d product %h sat %b mis %b last %b",
                             got.out_row, got.out_col, got.product, got.saturated,
                             got.misaligned, got.last);
                end
            end
        endfunction
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    mm_in_t               s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    mm_out_t              m_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_A_ROWS;
    logic [DIM_W-1:0]     cfg_wdata = '0;

    mm_scoreboard board = new();

    bit a_written [MAX_DIM_DEF*MAX_DIM_DEF];
    bit b_written [MAX_DIM_DEF*MAX_DIM_DEF];
    int items_sent   = 0;
    int shapes_run   = 0;
    int quiet_cycles = 0;
    int ready_hold   = 0;
    bit calm         = 1'b0;

    matrix_multiply #(
        .MAX_DIM(MAX_DIM_DEF)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver back-pressure: mostly short stalls, now and then a long one
    always @(posedge aclk) begin : recv_pace
        int pick;
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (calm) begin
            m_ready <= 1'b1;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                m_ready    <= 1'b1;
                ready_hold <= $urandom_range(0, 7);
            end else if (pick < 93) begin
                m_ready    <= 1'b0;
                ready_hold <= $urandom_range(0, 2);
            end else begin
                m_ready    <= 1'b0;
                ready_hold <= $urandom_range(15, 60);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) board.check_result(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
                $display("tb NOT OK");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic int pick_gap();
        int pick;
        if (calm) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [ELEM_W-1:0] rand_element();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFFFFFF;
            1:       return 32'sh80000000;
            2, 3, 4: return $urandom;
            default: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
        endcase
    endfunction

    // valid is left high on return; the next call or drain() settles it
    task automatic send_item(input logic sel, input int row, input int col,
                             input logic signed [ELEM_W-1:0] value, input logic go_bit);
        mm_in_t it;
        int gap;
        it.select_b  = sel;
        it.row_index = row[POS_W-1:0];
        it.col_index = col[POS_W-1:0];
        it.element   = value;
        it.go        = go_bit;
        if (sel) b_written[row*MAX_DIM_DEF + col] = 1'b1;
        else a_written[row*MAX_DIM_DEF + col] = 1'b1;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        board.note_input(it);
        items_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_shape(input logic [DIM_W-1:0] d0, input logic [DIM_W-1:0] d1,
                             input logic [DIM_W-1:0] d2, input logic [DIM_W-1:0] d3);
        logic [DIM_W-1:0] raw [4];
        raw = '{d0, d1, d2, d3};
        drain();
        cfg_we <= 1'b1;
        foreach (REG_ORDER[i]) begin
            cfg_index <= REG_ORDER[i];
            cfg_wdata <= raw[i];
            @(posedge aclk);
            board.write_reg(REG_ORDER[i], raw[i]);
        end
        cfg_we <= 1'b0;
        calm = ($urandom_range(0, 3) == 0);
        shapes_run++;
    endtask

    // load the operand entries the product needs, a few stray loads, then go
    task automatic load_and_go(input bit full_reload);
        int m, n, l, p;
        int slot_q [$];
        int t, pick, tmp, slot;
        m = mm_scoreboard::effective_dim(board.dims[REG_A_ROWS]);
        n = mm_scoreboard::effective_dim(board.dims[REG_A_COLS]);
        l = mm_scoreboard::effective_dim(board.dims[REG_B_ROWS]);
        p = mm_scoreboard::effective_dim(board.dims[REG_B_COLS]);
        if (m*n + n*p > 24) full_reload = 1'b0;
        if (n == l) begin
            for (int i = 0; i < m; i++)
                for (int k = 0; k < n; k++)
                    if (full_reload || !a_written[i*MAX_DIM_DEF + k])
                        slot_q.push_back(i*MAX_DIM_DEF + k);
            for (int k = 0; k < n; k++)
                for (int j = 0; j < p; j++)
                    if (full_reload || !b_written[k*MAX_DIM_DEF + j])
                        slot_q.push_back(64 + k*MAX_DIM_DEF + j);
        end
        repeat ($urandom_range(0, 3)) slot_q.push_back($urandom_range(0, 127));
        for (t = slot_q.size() - 1; t > 0; t--) begin
            pick         = $urandom_range(0, t);
            tmp          = slot_q[t];
            slot_q[t]    = slot_q[pick];
            slot_q[pick] = tmp;
        end
        foreach (slot_q[i]) begin
            slot = slot_q[i];
            send_item(slot >= 64, (slot % 64) / 8, slot % 8, rand_element(), 1'b0);
        end
        slot = $urandom_range(0, 127);
        send_item(slot >= 64, (slot % 64) / 8, slot % 8, rand_element(), 1'b1);
    endtask

    initial begin : stimulus
        logic [DIM_W-1:0] d0, d1, d2, d3;
        int pick;
        int rounds;
        bit max_done;
        max_done = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // 1x1 shapes from reset: saturation both ways, floor on negatives
        send_item(1'b0, 0, 0, 32'sh7FFFFFFF, 1'b0);
        send_item(1'b1, 0, 0, 32'sh7FFFFFFF, 1'b1);
        send_item(1'b0, 0, 0, 32'sh80000000, 1'b1);
        drain();
        send_item(1'b1, 0, 0, 32'sh80000000, 1'b1);
        send_item(1'b0, 0, 0, 32'shFFFFFFFF, 1'b0);
        send_item(1'b1, 0, 0, 32'sh00000001, 1'b1);
        send_item(1'b0, 0, 0, 32'sh00018000, 1'b0);
        send_item(1'b1, 0, 0, 32'shFFFE0000, 1'b1);
        send_item(1'b0, 7, 7, 32'sh00000000, 1'b0);
        send_item(1'b1, 7, 7, 32'shAAAAAAAA, 1'b1);

        // a_cols differs from b_rows
        set_shape(4'd1, 4'd2, 4'd1, 4'd1);
        send_item(1'b0, 3, 4, 32'sh55555555, 1'b1);

        // zero dimensions act as one
        set_shape(4'd0, 4'd0, 4'd0, 4'd0);
        send_item(1'b1, 0, 0, 32'sh00010000, 1'b1);

        set_shape(4'd2, 4'd1, 4'd1, 4'd2);
        send_item(1'b0, 1, 0, 32'shFFFF0000, 1'b0);
        send_item(1'b1, 0, 1, 32'sh7FFFFFFF, 1'b1);

        while (items_sent < ITEM_TARGET) begin
            if (!max_done && items_sent >= 110) begin
                // every register at or above the limit: full 8 x 8 times 8 x 8
                set_shape(4'd15, 4'd8, 4'd12, 4'd9);
                load_and_go(1'b0);
                max_done = 1'b1;
            end else begin
                pick = $urandom_range(0, 99);
                d0 = 4'($urandom_range(1, 3));
                d1 = 4'($urandom_range(1, 3));
                d2 = ($urandom_range(0, 6) != 0) ? d1 : 4'($urandom_range(1, 3));
                d3 = 4'($urandom_range(1, 3));
                if (pick >= 60 && pick < 85) begin
                    d0 = 4'($urandom_range(0, 15));
                    d1 = 4'($urandom_range(0, 15));
                    d2 = ($urandom_range(0, 2) != 0) ? d1 : 4'($urandom_range(0, 15));
                    d3 = 4'($urandom_range(0, 15));
                end else if (pick >= 85) begin
                    d2 = 4'((d1 % 3) + 1);
                end
                set_shape(d0, d1, d2, d3);
                rounds = $urandom_range(1, 3);
                for (int r = 0; r < rounds; r++) begin
                    if (r > 0 && $urandom_range(0, 1) == 1) drain();
                    load_and_go($urandom_range(0, 2) != 0);
                end
            end
        end

        drain();
        $display("covered %0d input transactions over %0d shapes, dimensions 0 to 15",
                 board.inputs_seen, shapes_run);
        $display("checked %0d results: %0d saturated, %0d misaligned, %0d mismatches",
                 board.results_seen, board.sat_seen, board.misaligned_seen, board.mismatches);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
